// ----- sv/bnip_pkg.sv -----
package bnip_pkg;

	// Widths fixed by the register and field formats.
	localparam int LEN_W     = 5;
	localparam int SYM_BITS  = 128;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;
	localparam int VAL_W     = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

	// Reset alphabet: decimal digits "0123456789".
	localparam logic [LEN_W-1:0]     RST_BASE_LENGTH  = 5'd10;
	localparam logic [CFG_DAT_W-1:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
	localparam logic [CFG_DAT_W-1:0] RST_SYMBOLS_HIGH = 64'h0000000000003938;
	localparam logic                 RST_BASE_OK      = 1'b1;

	// Characters with a special meaning.
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Parse phases of one string.
	typedef enum logic [1:0] {
		PH_SPACE = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// Alphabet facts derived from the configuration registers.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ok;
	} base_info_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

endpackage

// ----- sv/bnip_base_check.sv -----
module bnip_base_check import bnip_pkg::*; #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LEN_W-1:0]    base_length,
	input  logic [SYM_BITS-1:0] sym_all,
	output base_info_t          info
);

	logic [7:0]       sym [MAX_SYMBOLS];
	logic [LEN_W-1:0] used_len;
	logic [LEN_W-1:0] eff_len;
	logic             bad;
	base_info_t       info_q;

	// Split the packed alphabet into one byte per symbol lane.
	for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_sym
		assign sym[g] = sym_all[8*g +: 8];
	end

	// The alphabet is cut at the configured length (at most the lane count) and at the first zero symbol.
	always_comb begin
		used_len = (base_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : base_length;
		eff_len  = used_len;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if ((LEN_W'(i) < used_len) && (sym[i] == CH_NUL)) begin
				eff_len = LEN_W'(i);
			end
		end
	end

	// A usable alphabet has no sign or blank symbols and no repeats.
	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (LEN_W'(i) < eff_len) begin
				if (is_sign(sym[i]) || is_blank(sym[i])) begin
					bad = 1'b1;
				end
				for (int j = 0; j < i; j++) begin
					if (sym[j] == sym[i]) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

	// Registered so that the digit path sees a settled length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_q.len <= RST_BASE_LENGTH;
			info_q.ok  <= RST_BASE_OK;
		end else begin
			info_q.len <= eff_len;
			info_q.ok  <= !bad && (eff_len >= LEN_W'(2));
		end
	end

	assign info = info_q;

endmodule

// ----- sv/base_n_integer_parser_core.sv -----
// Signed integer parser for a configurable radix, one character per beat.
// Input channel (in_valid/in_ready) carries ch and last; a beat with last set
// closes the string. Leading blanks are skipped, then any run of '+' and '-'
// sets the sign, then digits from the configured alphabet accumulate. The
// first non-digit ends the number and later characters of the string are
// dropped.
// Output channel (out_valid/out_ready) carries one beat per string: value
// (wraps modulo 2^32) and base_ok for the alphabet in use.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// base_length, symbols_low, symbols_high; write only while the parser is idle.
// Path: a character is held in the input register; the result of a string is
// registered in the output register when its last beat leaves the input register.
// Throughput: one character per cycle when not stalled by a config write,
// set by the accumulator multiply-add loop, which retires one digit each cycle.
// Stall: while a result waits for out_ready, characters of the next string
// still flow; only a further last beat waits in the input register.
// Reset: parse state clears and the alphabet returns to decimal "0123456789".
module base_n_integer_parser_core import bnip_pkg::*; #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 ch,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VAL_W-1:0]    value,
	output logic                       base_ok,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_data
);

	localparam int POS_W = $clog2(MAX_SYMBOLS);

	logic [LEN_W-1:0]     length_q;
	logic [CFG_DAT_W-1:0] sym_lo_q;
	logic [CFG_DAT_W-1:0] sym_hi_q;
	logic [SYM_BITS-1:0]  sym_all;
	logic [7:0]           sym [MAX_SYMBOLS];
	base_info_t           info;

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	logic                 adv_s1;

	phase_t               phase_q;
	phase_t               ph_pre;
	phase_t               ph_mid;
	phase_t               phase_nx;
	logic                 neg_q;
	logic                 neg_nx;
	logic [VAL_W-1:0]     acc_q;
	logic [VAL_W-1:0]     acc_mul;
	logic [VAL_W-1:0]     acc_nx;
	logic                 hit;
	logic [POS_W-1:0]     pos;
	logic                 flip;
	logic [VAL_W-1:0]     result;

	logic                 out_valid_q;
	logic [VAL_W-1:0]     value_q;
	logic                 base_ok_q;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= RST_BASE_LENGTH;
			sym_lo_q <= RST_SYMBOLS_LOW;
			sym_hi_q <= RST_SYMBOLS_HIGH;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_LENGTH:  length_q <= cfg_data[LEN_W-1:0];
				CFG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				CFG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sym_all = {sym_hi_q, sym_lo_q};

	for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_sym
		assign sym[g] = sym_all[8*g +: 8];
	end

	bnip_base_check #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_base_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_length(length_q),
		.sym_all    (sym_all),
		.info       (info)
	);

	// Input register. A last beat waits here while the output is still full;
	// no beat is taken in the cycle of a config write.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = (!valid_s1 || adv_s1) && !cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// Digit lookup: lowest matching symbol inside the effective length.
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if ((sym[i] == ch_s1) && (LEN_W'(i) < info.len)) begin
				hit = 1'b1;
				pos = POS_W'(i);
			end
		end
	end

	// Next phase: blanks, then signs, then digits, then done until last.
	always_comb begin
		ph_pre = phase_q;
		if ((phase_q == PH_SPACE) && !is_blank(ch_s1)) begin
			ph_pre = PH_SIGN;
		end
		ph_mid = ph_pre;
		if ((ph_pre == PH_SIGN) && !is_sign(ch_s1)) begin
			ph_mid = PH_DIGIT;
		end
		phase_nx = ph_mid;
		if ((ph_mid == PH_DIGIT) && !hit) begin
			phase_nx = PH_DONE;
		end
	end

	// Sign flip and accumulator multiply-add for this character.
	always_comb begin
		flip    = (ph_pre == PH_SIGN) && (ch_s1 == CH_MINUS);
		neg_nx  = neg_q ^ flip;
		acc_mul = VAL_W'(acc_q * VAL_W'(info.len));
		acc_nx  = acc_q;
		if ((ph_mid == PH_DIGIT) && hit) begin
			acc_nx = acc_mul + VAL_W'(pos);
		end
		result = neg_nx ? (VAL_W'(0) - acc_nx) : acc_nx;
	end

	// Parse state; a last beat returns it to the start of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_nx;
				neg_q   <= neg_nx;
				acc_q   <= acc_nx;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			value_q   <= result;
			base_ok_q <= info.ok;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign base_ok   = base_ok_q;

	// A beat is only taken when the input register has room.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!valid_s1 || adv_s1))
		else $error("input register overwritten");

	// A closed string leaves a clean parse state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (phase_q == PH_SPACE && acc_q == '0 && !neg_q))
		else $error("parse state not cleared after last beat");

	// Once parsing ended, it stays ended until the string closes.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !(adv_s1 && last_s1)) |=> (phase_q == PH_DONE))
		else $error("parser left the done phase early");

	// A result appears only for a last beat.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result without a last beat");

	// The effective alphabet never exceeds the lane count.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		info.len <= LEN_W'(MAX_SYMBOLS))
		else $error("effective length out of range");

endmodule

// ----- tb/tb.sv -----
module tb;
	import bnip_pkg::*;

	localparam int NSYM        = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int CHAR_TOTAL  = 1800;

	// Index 3 has no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] c;
		logic       lst;
	} char_beat_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
	} reg_write_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    ok;
	} parsed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [7:0]              ch = '0;
	logic                    last = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] value;
	logic                    base_ok;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DAT_W-1:0]    cfg_data = '0;

	char_beat_t pending_chars[$];
	reg_write_t pending_writes[$];
	parsed_t    expected_numbers[$];

	int chars_queued = 0;
	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	// Idle bookkeeping for the two data channels.
	int in_wait = 0;
	int in_calm = 0;
	int out_wait = 0;
	int out_calm = 0;

	// Alphabet as last written, used to build strings that actually parse.
	logic [LEN_W-1:0]    g_blen = RST_BASE_LENGTH;
	logic [SYM_BITS-1:0] g_syms = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};

	// Parser state as predicted from accepted beats.
	logic [LEN_W-1:0]    p_blen;
	logic [SYM_BITS-1:0] p_syms;
	phase_t              p_phase;
	logic                p_neg;
	logic [VAL_W-1:0]    p_acc;

	base_n_integer_parser_core #(
		.MAX_SYMBOLS(NSYM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.base_ok(base_ok),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	// The alphabet stops at the first zero symbol and never exceeds NSYM.
	function automatic int alpha_len(input logic [LEN_W-1:0] blen,
			input logic [SYM_BITS-1:0] syms);
		int n;
		n = (blen > NSYM) ? NSYM : int'(blen);
		for (int i = 0; i < n; i++)
			if (syms[i*8 +: 8] == CH_NUL)
				return i;
		return n;
	endfunction

	function automatic logic alpha_ok(input int len, input logic [SYM_BITS-1:0] syms);
		logic [7:0] s;
		for (int i = 0; i < len; i++) begin
			s = syms[i*8 +: 8];
			if (s == CH_PLUS || s == CH_MINUS || blank_char(s))
				return 1'b0;
			for (int j = 0; j < i; j++)
				if (syms[j*8 +: 8] == s)
					return 1'b0;
		end
		return len >= 2;
	endfunction

	// Lowest matching symbol index, or len when the character is no digit.
	function automatic int digit_index(input logic [7:0] c, input int len,
			input logic [SYM_BITS-1:0] syms);
		for (int i = 0; i < len; i++)
			if (syms[i*8 +: 8] == c)
				return i;
		return len;
	endfunction

	// Gap lengths: mostly none or short, a few long, and calm stretches.
	function automatic int draw_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm = $urandom_range(30, 150);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// Characters that tend to stop or confuse the parser.
	function automatic logic [7:0] junk_char();
		int n;
		n = alpha_len(g_blen, g_syms);
		case ($urandom_range(0, 5))
			0: return any_blank();
			1: return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
			2: return CH_NUL;
			3: return (n > 0) ? g_syms[$urandom_range(0, n - 1)*8 +: 8] : 8'($urandom);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sixteen distinct nonzero symbols, mostly printable.
	function automatic logic [SYM_BITS-1:0] fresh_alphabet();
		logic [SYM_BITS-1:0] a;
		bit [255:0] used;
		logic [7:0] s;
		used = '0;
		for (int i = 0; i < NSYM; i++) begin
			do begin
				s = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(33, 126))
					: 8'($urandom_range(1, 255));
			end while (used[s]);
			used[s] = 1'b1;
			a[i*8 +: 8] = s;
		end
		return a;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("ERROR result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	// Advance the predicted parser by one character beat.
	task automatic parse_char(input logic [7:0] c, input logic lst);
		int len;
		int pos;
		parsed_t r;
		len = alpha_len(p_blen, p_syms);
		if (p_phase == PH_SPACE && !blank_char(c))
			p_phase = PH_SIGN;
		if (p_phase == PH_SIGN) begin
			if (c == CH_MINUS)
				p_neg = ~p_neg;
			else if (c != CH_PLUS)
				p_phase = PH_DIGIT;
		end
		if (p_phase == PH_DIGIT) begin
			pos = digit_index(c, len, p_syms);
			if (pos < len)
				p_acc = p_acc * len + pos;
			else
				p_phase = PH_DONE;
		end
		if (lst) begin
			r.value = p_neg ? -p_acc : p_acc;
			r.ok = alpha_ok(len, p_syms);
			expected_numbers.push_back(r);
			p_phase = PH_SPACE;
			p_neg = 1'b0;
			p_acc = '0;
		end
	endtask

	task automatic add_beat(input logic [7:0] c, input logic lst);
		char_beat_t b;
		b.c = c;
		b.lst = lst;
		pending_chars.push_back(b);
		chars_queued++;
	endtask

	task automatic add_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			add_beat(s[i], close && i == s.len() - 1);
	endtask

	// Mostly well-formed strings for the current alphabet, some pure noise.
	task automatic add_string();
		int n;
		int cnt;
		logic [7:0] s[$];
		n = alpha_len(g_blen, g_syms);
		if ($urandom_range(0, 3) != 0) begin
			cnt = $urandom_range(0, 3);
			repeat (cnt) s.push_back(any_blank());
			cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
			repeat (cnt) s.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
			cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
			if (n > 0)
				repeat (cnt) s.push_back(g_syms[$urandom_range(0, n - 1)*8 +: 8]);
			cnt = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
			repeat (cnt) s.push_back(junk_char());
		end else begin
			cnt = $urandom_range(1, 8);
			repeat (cnt) s.push_back(junk_char());
		end
		if (s.size() == 0)
			s.push_back(junk_char());
		foreach (s[i])
			add_beat(s[i], i == s.size() - 1);
	endtask

	task automatic run_strings(input int target);
		int stop;
		stop = chars_queued + target;
		while (chars_queued < stop)
			add_string();
	endtask

	// Wait until every beat is in, every result is out and the pipe is empty.
	task automatic settle();
		do @(negedge clk);
		while (pending_chars.size() != 0 || in_valid || expected_numbers.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		reg_write_t w;
		w.idx = idx;
		w.data = data;
		pending_writes.push_back(w);
		case (idx)
			CFG_BASE_LENGTH: g_blen = data[LEN_W-1:0];
			CFG_SYMBOLS_LOW: g_syms[63:0] = data;
			CFG_SYMBOLS_HIGH: g_syms[127:64] = data;
			default: ;
		endcase
	endtask

	// Write all three registers; the upper bits of the length word are noise.
	task automatic configure(input logic [LEN_W-1:0] blen, input logic [63:0] lo,
			input logic [63:0] hi);
		push_write(CFG_BASE_LENGTH,
			{(CFG_DAT_W-LEN_W)'({$urandom, $urandom} >> LEN_W), blen});
		push_write(CFG_SYMBOLS_LOW, lo);
		push_write(CFG_SYMBOLS_HIGH, hi);
		do @(negedge clk);
		while (pending_writes.size() != 0 || cfg_valid);
	endtask

	// Driver: one beat per channel at a rising edge, unless a random gap or a stall holds it.
	always @(posedge clk or negedge arst_n) begin
		char_beat_t b;
		reg_write_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			last <= 1'b0;
			out_ready <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			if (!in_valid || in_ready) begin
				if (in_wait > 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					b = pending_chars.pop_front();
					in_valid <= 1'b1;
					ch <= b.c;
					last <= b.lst;
					in_wait = draw_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end

			if (out_wait > 0) begin
				out_ready <= 1'b0;
				out_wait--;
			end else begin
				out_ready <= 1'b1;
				out_wait = ($urandom_range(0, 2) == 0) ? draw_gap(out_calm) : 0;
			end

			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					w = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks result beats, then predicts from accepted input beats.
	always @(posedge clk or negedge arst_n) begin
		parsed_t e;
		if (!arst_n) begin
			p_blen = RST_BASE_LENGTH;
			p_syms = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
			p_phase = PH_SPACE;
			p_neg = 1'b0;
			p_acc = '0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_numbers.size() == 0) begin
					flag_mismatch("unexpected value", value, 0);
				end else begin
					e = expected_numbers.pop_front();
					if (value !== e.value)
						flag_mismatch("value", value, e.value);
					if (base_ok !== e.ok)
						flag_mismatch("base_ok", base_ok, e.ok);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BASE_LENGTH: p_blen = cfg_data[LEN_W-1:0];
					CFG_SYMBOLS_LOW: p_syms[63:0] = cfg_data;
					CFG_SYMBOLS_HIGH: p_syms[127:64] = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				parse_char(ch, last);

			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: a long stretch without any beat means the block is stuck.
	initial begin
		do @(posedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [SYM_BITS-1:0] a;
		logic [LEN_W-1:0] blen;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Decimal after reset: blanks, sign runs, blank after a sign,
		// a zero byte inside the digits, a lone high byte and a wrap.
		add_beat(CH_TAB, 1'b0);
		add_beat(CH_VT, 1'b0);
		add_text("-+-7", 1'b1);
		add_text("- 5", 1'b1);
		add_beat(CH_LF, 1'b0);
		add_beat(CH_FF, 1'b0);
		add_beat(CH_CR, 1'b0);
		add_beat(CH_SPACE, 1'b0);
		add_text("9", 1'b0);
		add_beat(CH_NUL, 1'b0);
		add_text("3", 1'b1);
		add_beat(8'hff, 1'b1);
		add_text("4294967301", 1'b1);
		settle();
		run_strings(120);
		settle();

		// Hexadecimal, plus a write to the unused index.
		push_write(CFG_UNUSED, {$urandom, $urandom});
		configure(5'd16, RST_SYMBOLS_LOW, 64'h4645444342413938);
		run_strings(120);
		settle();

		// Smallest valid radix.
		configure(5'd2, 64'h3130, 64'h0);
		run_strings(100);
		settle();

		// Empty and single-symbol alphabets.
		configure(5'd0, RST_SYMBOLS_LOW, RST_SYMBOLS_HIGH);
		run_strings(60);
		settle();
		configure(5'd1, 64'h78, 64'h0);
		run_strings(60);
		settle();

		// Largest length field, clipped to the symbol count.
		configure(5'd31, 64'(fresh_alphabet() >> 64), 64'(fresh_alphabet() >> 64));
		run_strings(100);
		settle();

		// Every symbol bit set: all duplicates.
		configure(5'd16, '1, '1);
		run_strings(60);
		settle();

		// A zero symbol cuts the alphabet short.
		configure(5'd10, 64'h3736350033323130, RST_SYMBOLS_HIGH);
		run_strings(80);
		settle();

		// Repeated symbols resolve to the lowest index.
		configure(5'd8, 64'h3534333031323130, 64'h0);
		run_strings(80);
		settle();

		// Blank and sign characters among the symbols.
		configure(5'd8, 64'h65646362612b2d20, 64'h0);
		run_strings(80);
		settle();

		// All symbol bits clear.
		configure(5'd5, '0, '0);
		run_strings(40);
		settle();

		// Random alphabets until the character budget is spent.
		while (chars_queued < CHAR_TOTAL) begin
			blen = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(2, 16));
			if ($urandom_range(0, 3) == 0)
				a = {$urandom, $urandom, $urandom, $urandom};
			else
				a = fresh_alphabet();
			configure(blen, a[63:0], a[127:64]);
			run_strings(120);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
